// ----- hdl/ppd_pkg.sv -----
package ppd_pkg;

  localparam int TIME_W = 24;
  localparam int VEL_W  = 24;
  localparam int DRAG_W = 16;
  localparam int POS_W  = 48;

  localparam int LOG_TABLE_ENTRIES = 256;
  localparam int LOG_N = $clog2(LOG_TABLE_ENTRIES);

  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [19:0] GRAV_Q16  = 20'd648151;

  // w = 2^34 + k*|v|*t stays below 2^63
  localparam int W_W    = 63;
  localparam int EXP_W  = 5;
  localparam int LN_W   = 37;
  localparam int QUOT_W = 29;
  localparam int LIN_W  = 38;
  localparam int GRV_W  = 40;

  localparam int DRAG_LAT   = 8 + QUOT_W;
  localparam int PIPE_DEPTH = DRAG_LAT + 4;

  typedef enum logic [1:0] {
    REG_VEL_X = 2'd0,
    REG_VEL_Y = 2'd1,
    REG_VEL_Z = 2'd2,
    REG_DRAG  = 2'd3
  } cfg_reg_e;

  typedef logic [31:0] ln_tab_t [0:LOG_TABLE_ENTRIES];

  // shift-subtract quotient, only evaluated while building the table
  function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r    = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1 + i/N) in Q32 via 2*atanh(s), s = i/(2N+i)
  function automatic ln_tab_t build_ln_tab();
    ln_tab_t tab;
    longint unsigned n, s, s2, p, sum;
    n = longint'(LOG_TABLE_ENTRIES);
    for (int i = 0; i <= LOG_TABLE_ENTRIES; i++) begin
      s   = udiv64(longint'(i) << 32, 2 * n + longint'(i));
      s2  = (s * s + 64'h8000_0000) >> 32;
      p   = s;
      sum = s;
      for (int k = 3; k < 64; k += 2) begin
        if (p != 0) begin
          p   = (p * s2 + 64'h8000_0000) >> 32;
          sum = sum + udiv64(p, longint'(k));
        end
      end
      tab[i] = 32'(2 * sum);
    end
    return tab;
  endfunction

  localparam ln_tab_t LN_TAB = build_ln_tab();

endpackage

// ----- hdl/projectile_position_with_drag.sv -----
// Fully pipelined: one item per cycle, sustained while the output is not stalled;
// no dependence between items.
// Depth is set by the bit-per-stage divider of the drag path (29 stages).
// The whole pipe advances together; it holds while the output waits.
// Reset (rst_ni low, async) clears all valid bits and the config registers to zero.
module projectile_position_with_drag
  import ppd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [23:0]   cfg_wdata_i,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [23:0]   s_axis_tdata,   // time_stamp
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [143:0]  m_axis_tdata    // pos_x, pos_y, pos_z
);

  logic [VEL_W-1:0]  vel_x_q, vel_y_q, vel_z_q;
  logic [DRAG_W-1:0] drag_q;
  logic [PIPE_DEPTH-1:0] vld_q;
  logic              en;
  logic [TIME_W-1:0] t_q [0:DRAG_LAT];
  logic [VEL_W-1:0]  mag_x, mag_y, mag_z;
  logic [QUOT_W-1:0] qx, qy;

  logic [2*TIME_W-1:0] mtx_a_q, mty_a_q, mtz_a_q, tt_a_q;
  logic [QUOT_W-1:0]   qx_a_q, qy_a_q, qx_b_q, qy_b_q;
  logic [LIN_W-1:0]    linx_b_q, liny_b_q, linz_b_q;
  logic [43:0]         ghi_b_q, glo_b_q;
  logic [GRV_W-1:0]    grav;
  logic [POS_W-1:0]    px_d, py_d, pz_d, px_q, py_q, pz_q;
  logic [POS_W-1:0]    linz_e, grav_e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_x_q <= '0;
      vel_y_q <= '0;
      vel_z_q <= '0;
      drag_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_VEL_X: vel_x_q <= cfg_wdata_i;
        REG_VEL_Y: vel_y_q <= cfg_wdata_i;
        REG_VEL_Z: vel_z_q <= cfg_wdata_i;
        REG_DRAG:  drag_q  <= cfg_wdata_i[DRAG_W-1:0];
      endcase
    end
  end

  assign mag_x = vel_x_q[VEL_W-1] ? VEL_W'(-vel_x_q) : vel_x_q;
  assign mag_y = vel_y_q[VEL_W-1] ? VEL_W'(-vel_y_q) : vel_y_q;
  assign mag_z = vel_z_q[VEL_W-1] ? VEL_W'(-vel_z_q) : vel_z_q;

  assign en            = !vld_q[PIPE_DEPTH-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[PIPE_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q[0] <= s_axis_tdata;
      for (int i = 1; i <= DRAG_LAT; i++) begin
        t_q[i] <= t_q[i-1];
      end
    end
  end

  ppd_drag u_drag_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .t_i    (t_q[0]),
    .mag_i  (mag_x),
    .drag_i (drag_q),
    .quot_o (qx)
  );

  ppd_drag u_drag_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .t_i    (t_q[0]),
    .mag_i  (mag_y),
    .drag_i (drag_q),
    .quot_o (qy)
  );

  assign grav = GRV_W'(((69'(ghi_b_q) << 24) + 69'(glo_b_q) + (69'(1) << 28)) >> 29);
  assign linz_e = POS_W'(linz_b_q);
  assign grav_e = POS_W'(grav);

  always_comb begin
    if (drag_q == '0) begin
      px_d = vel_x_q[VEL_W-1] ? -POS_W'(linx_b_q) : POS_W'(linx_b_q);
      py_d = vel_y_q[VEL_W-1] ? -POS_W'(liny_b_q) : POS_W'(liny_b_q);
    end else begin
      px_d = vel_x_q[VEL_W-1] ? -POS_W'(qx_b_q) : POS_W'(qx_b_q);
      py_d = vel_y_q[VEL_W-1] ? -POS_W'(qy_b_q) : POS_W'(qy_b_q);
    end
    // gravity term flips sign with vz, like the linear term
    pz_d = vel_z_q[VEL_W-1] ? grav_e - linz_e : linz_e - grav_e;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mtx_a_q  <= mag_x * t_q[DRAG_LAT];
      mty_a_q  <= mag_y * t_q[DRAG_LAT];
      mtz_a_q  <= mag_z * t_q[DRAG_LAT];
      tt_a_q   <= t_q[DRAG_LAT] * t_q[DRAG_LAT];
      qx_a_q   <= qx;
      qy_a_q   <= qy;
      linx_b_q <= LIN_W'((mtx_a_q + 48'd512) >> 10);
      liny_b_q <= LIN_W'((mty_a_q + 48'd512) >> 10);
      linz_b_q <= LIN_W'((mtz_a_q + 48'd512) >> 10);
      ghi_b_q  <= tt_a_q[47:24] * GRAV_Q16;
      glo_b_q  <= tt_a_q[23:0] * GRAV_Q16;
      qx_b_q   <= qx_a_q;
      qy_b_q   <= qy_a_q;
      px_q     <= px_d;
      py_q     <= py_d;
      pz_q     <= pz_d;
    end
  end

  assign m_axis_tdata = {pz_q, py_q, px_q};

endmodule

// ----- hdl/ppd_drag.sv -----
module ppd_drag
  import ppd_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [TIME_W-1:0] t_i,
  input  logic [VEL_W-1:0]  mag_i,
  input  logic [DRAG_W-1:0] drag_i,
  output logic [QUOT_W-1:0] quot_o
);

  logic [DRAG_W+VEL_W-1:0]    km_a_q;
  logic [TIME_W-1:0]          t_a_q;
  logic [DRAG_W+VEL_W+11:0]   phi_b_q, plo_b_q;
  logic [W_W-1:0]             w_c_q, w_d_q;
  logic [EXP_W-1:0]           ex_d, ex_d_q, ex_e_q, ex_f_q;
  logic [31:0]                g_e_q;
  logic [LOG_N-1:0]           idx;
  logic [LOG_N:0]             idx_hi;
  logic [31:0]                lo, hi;
  logic [31:0]                lo_f_q, dif_f_q, fr_f_q;
  logic [63:0]                prod_g_q;
  logic [LN_W-1:0]            base_g_q;
  logic [LN_W:0]              ln_h;

  logic [DRAG_W-1:0] rem_q [0:QUOT_W];
  logic [QUOT_W-1:0] nq_q  [0:QUOT_W];

  always_comb begin
    ex_d = '0;
    for (int b = 34; b < W_W; b++) begin
      if (w_c_q[b]) begin
        ex_d = EXP_W'(b - 34);
      end
    end
  end

  assign idx    = g_e_q[31 -: LOG_N];
  assign idx_hi = {1'b0, idx} + 1'b1;
  assign lo     = LN_TAB[idx];
  assign hi     = LN_TAB[idx_hi];

  assign ln_h = {1'b0, base_g_q}
              + (LN_W+1)'((65'(prod_g_q) + 65'h0_8000_0000) >> 32);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      km_a_q   <= drag_i * mag_i;
      t_a_q    <= t_i;
      phi_b_q  <= km_a_q * t_a_q[23:12];
      plo_b_q  <= km_a_q * t_a_q[11:0];
      w_c_q    <= (W_W'(1) << 34) + (W_W'(phi_b_q) << 12) + W_W'(plo_b_q);
      w_d_q    <= w_c_q;
      ex_d_q   <= ex_d;
      g_e_q    <= 32'(w_d_q >> (ex_d_q + 2'd2));
      ex_e_q   <= ex_d_q;
      lo_f_q   <= lo;
      dif_f_q  <= (hi >= lo) ? hi - lo : '0;
      fr_f_q   <= {g_e_q[31-LOG_N:0], LOG_N'(0)};
      ex_f_q   <= ex_e_q;
      prod_g_q <= dif_f_q * fr_f_q;
      base_g_q <= LN_W'(ex_f_q) * LN_W'(LN2_Q32) + LN_W'(lo_f_q);
      rem_q[0] <= '0;
      nq_q[0]  <= QUOT_W'((ln_h + (LN_W+1)'({drag_i, 7'd0})) >> 8);
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < QUOT_W; j++) begin : g_div
    logic [DRAG_W:0]   trial;
    logic              ge;
    logic [DRAG_W-1:0] rem_d;
    assign trial = {rem_q[j], nq_q[j][QUOT_W-1]};
    assign ge    = trial >= {1'b0, drag_i};
    assign rem_d = ge ? DRAG_W'(trial - {1'b0, drag_i}) : trial[DRAG_W-1:0];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= rem_d;
        nq_q[j+1]  <= {nq_q[j][QUOT_W-2:0], ge};
      end
    end
  end

  assign quot_o = nq_q[QUOT_W];

endmodule

// ----- tb/tb_projectile_position_with_drag.sv -----
module tb_projectile_position_with_drag;
  import ppd_pkg::*;

  logic          clk_i;
  logic          rst_ni;
  logic          cfg_we_i;
  logic [1:0]    cfg_idx_i;
  logic [23:0]   cfg_wdata_i;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [23:0]   s_axis_tdata;   // time_stamp
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [143:0]  m_axis_tdata;   // pos_x, pos_y, pos_z

  projectile_position_with_drag dut (.*);

  typedef struct packed {
    logic [47:0] z;
    logic [47:0] y;
    logic [47:0] x;
  } pos_t;

  localparam longint unsigned LIMIT = 400000;

  pos_t            pos_q[$];
  int              n_err;
  longint unsigned cyc;
  logic [23:0]     vx_r, vy_r, vz_r;
  logic [15:0]     k_r;
  longint unsigned log_tab[0:LOG_TABLE_ENTRIES];
  int              hold_off;
  int              gap_pct;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cyc = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc > LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic build_log_tab();
    longint unsigned n, s, s2, p, sum;
    n = LOG_TABLE_ENTRIES;
    for (int i = 0; i <= LOG_TABLE_ENTRIES; i++) begin
      s = (longint'(i) << 32) / (2 * n + i);
      s2 = (s * s + 64'h8000_0000) >> 32;
      p = s;
      sum = s;
      for (int k = 3; k < 64 && p != 0; k += 2) begin
        p = (p * s2 + 64'h8000_0000) >> 32;
        sum += p / k;
      end
      log_tab[i] = 2 * sum;
    end
  endtask

  function automatic longint signed rnd_lin(logic [23:0] v, longint unsigned t);
    longint signed sv;
    longint unsigned m;
    sv = longint'(signed'(v));
    m = (sv < 0 ? -sv : sv) * t;
    m = (m + 512) >> 10;
    return sv < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned grav(longint unsigned t);
    logic [127:0] p;
    p = 128'(648151) * t * t + (128'd1 << 28);
    return 64'(p >> 29);
  endfunction

  function automatic longint signed drag_pos(logic [23:0] v, longint unsigned t,
                                             longint unsigned k);
    longint signed sv;
    longint unsigned m, w, g, pr, idx, fr, lo, hi, d, l, dv;
    int e;
    sv = longint'(signed'(v));
    m = sv < 0 ? -sv : sv;
    w = (64'd1 << 34) + k * m * t;
    e = 63;
    while (e > 34 && w[e] == 1'b0) e--;
    g = (w - (64'd1 << e)) >> (e - 32);
    pr = g * LOG_TABLE_ENTRIES;
    idx = pr >> 32;
    fr = pr & 64'hFFFF_FFFF;
    if (idx >= LOG_TABLE_ENTRIES) idx = LOG_TABLE_ENTRIES - 1;
    lo = log_tab[idx];
    hi = log_tab[idx + 1];
    d = hi >= lo ? hi - lo : 0;
    l = longint'(e - 34) * 64'd2977044472 + lo + ((d * fr + 64'h8000_0000) >> 32);
    dv = k * 256;
    l = (l + dv / 2) / dv;
    return sv < 0 ? -longint'(l) : longint'(l);
  endfunction

  function automatic pos_t predict_pos(logic [23:0] ts);
    pos_t r;
    longint signed gz, z;
    if (k_r == 0) begin
      r.x = 48'(rnd_lin(vx_r, ts));
      r.y = 48'(rnd_lin(vy_r, ts));
    end else begin
      r.x = 48'(drag_pos(vx_r, ts, k_r));
      r.y = 48'(drag_pos(vy_r, ts, k_r));
    end
    gz = longint'(grav(ts));
    z = rnd_lin(vz_r, ts) - (vz_r[23] ? -gz : gz);
    r.z = 48'(z);
    return r;
  endfunction

  task automatic report(string what, logic [47:0] got, logic [47:0] exp_v);
    n_err++;
    $display("mismatch %s: got %h exp %h", what, got, exp_v);
  endtask

  initial begin
    pos_t g, e;
    int stall;
    m_axis_tready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        g = m_axis_tdata;
        if (pos_q.size() == 0) begin
          report("unexpected item", g.x, '0);
        end else begin
          e = pos_q.pop_front();
          if (g.x !== e.x) report("pos_x", g.x, e.x);
          if (g.y !== e.y) report("pos_y", g.y, e.y);
          if (g.z !== e.z) report("pos_z", g.z, e.z);
        end
      end
      if (hold_off > 0) begin
        hold_off--;
        m_axis_tready <= 1'b0;
      end else begin
        stall = (stall + 1) % 23;
        m_axis_tready <= (cyc / 400) % 3 == 0 ? 1'b1 : (stall % 5 != 0);
      end
    end
  end

  task automatic send_time(logic [23:0] ts);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= ts;
    do @(posedge clk_i); while (!s_axis_tready);
    pos_q.push_back(predict_pos(ts));
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  task automatic idle_sender();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [23:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_VEL_X: vx_r = val;
      REG_VEL_Y: vy_r = val;
      REG_VEL_Z: vz_r = val;
      REG_DRAG:  k_r = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    idle_sender();
    while (pos_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
  endtask

  task automatic set_flight(logic [23:0] x, logic [23:0] y, logic [23:0] z,
                            logic [15:0] k);
    drain();
    write_reg(REG_VEL_X, x);
    write_reg(REG_VEL_Y, y);
    write_reg(REG_VEL_Z, z);
    write_reg(REG_DRAG, {8'd0, k});
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_reset_values();
    gap_pct = 0;
    send_time(24'd0);
    send_time(24'hFFFFFF);
    send_time(24'd1024);
  endtask

  task automatic test_directed();
    logic [23:0] ts[6] = '{24'd0, 24'd1, 24'd511, 24'd512, 24'h800000, 24'hFFFFFF};
    set_flight(24'h7FFFFF, 24'h800000, 24'h800000, 16'd0);
    foreach (ts[i]) send_time(ts[i]);
    set_flight(24'hFFFFFF, 24'd1, 24'h7FFFFF, 16'hFFFF);
    foreach (ts[i]) send_time(ts[i]);
    set_flight(24'h800000, 24'h7FFFFF, 24'd0, 16'd1);
    foreach (ts[i]) send_time(ts[i]);
    set_flight(24'd0, 24'h555555, 24'hAAAAAA, 16'h5555);
    send_time(24'h555555);
    send_time(24'hAAAAAA);
  endtask

  task automatic test_backpressure();
    set_flight(24'd25600, 24'hFF9C00, 24'd5000, 16'd300);
    gap_pct = 0;
    hold_off = 300;
    for (int i = 0; i < 120; i++) send_time(24'($urandom));
  endtask

  function automatic logic [23:0] rand_vel();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(51200) - 25600);
      2: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($urandom_range(2560) - 1280);
    endcase
  endfunction

  task automatic test_random();
    logic [15:0] k;
    for (int ph = 0; ph < 14; ph++) begin
      case (ph % 4)
        0: k = 16'd0;
        1: k = 16'($urandom);
        2: k = $urandom_range(1) ? 16'hFFFF : 16'd1;
        default: k = 16'($urandom_range(200));
      endcase
      set_flight(rand_vel(), rand_vel(), rand_vel(), k);
      gap_pct = $urandom_range(1) ? 0 : $urandom_range(60);
      for (int i = 0; i < 130; i++)
        send_time($urandom_range(3) == 0 ? 24'($urandom_range(4096)) : 24'($urandom));
    end
  endtask

  initial begin
    n_err = 0;
    hold_off = 0;
    gap_pct = 0;
    vx_r = '0; vy_r = '0; vz_r = '0; k_r = '0;
    build_log_tab();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_VEL_X;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_directed();
    test_backpressure();
    test_random();
    drain();
    if (n_err == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
